/* rtl/ebalu_pkg.sv */
// Shared types and constants of the 8-bit CPU ALU pipeline.
package ebalu_pkg;

    localparam logic [4:0] CMD_ADD    = 5'd0;
    localparam logic [4:0] CMD_ADC    = 5'd1;
    localparam logic [4:0] CMD_SUB    = 5'd2;
    localparam logic [4:0] CMD_SBC    = 5'd3;
    localparam logic [4:0] CMD_AND    = 5'd4;
    localparam logic [4:0] CMD_OR     = 5'd5;
    localparam logic [4:0] CMD_XOR    = 5'd6;
    localparam logic [4:0] CMD_INC    = 5'd7;
    localparam logic [4:0] CMD_DEC    = 5'd8;
    localparam logic [4:0] CMD_DAA    = 5'd9;
    localparam logic [4:0] CMD_RLC    = 5'd10;
    localparam logic [4:0] CMD_RRC    = 5'd11;
    localparam logic [4:0] CMD_RL     = 5'd12;
    localparam logic [4:0] CMD_RR     = 5'd13;
    localparam logic [4:0] CMD_SLA    = 5'd14;
    localparam logic [4:0] CMD_SRA    = 5'd15;
    localparam logic [4:0] CMD_SWAP   = 5'd16;
    localparam logic [4:0] CMD_SRL    = 5'd17;
    localparam logic [4:0] CMD_BIT    = 5'd18;
    localparam logic [4:0] CMD_RES    = 5'd19;
    localparam logic [4:0] CMD_SET    = 5'd20;
    localparam logic [4:0] CMD_RLCA   = 5'd21;
    localparam logic [4:0] CMD_RRCA   = 5'd22;
    localparam logic [4:0] CMD_RLA    = 5'd23;
    localparam logic [4:0] CMD_RRA    = 5'd24;
    localparam logic [4:0] CMD_ADD16  = 5'd25;
    localparam logic [4:0] CMD_ADD16S = 5'd26;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [7:0] DAA_HI_LIM = 8'h99;
    localparam logic [3:0] DAA_LO_LIM = 4'h9;

    typedef struct packed {
        logic [4:0]  command;
        logic [15:0] first_operand;
        logic [15:0] second_operand;
        logic [2:0]  bit_index;
        logic [3:0]  flags_in;
    } t_alu_in;

    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags_out;
    } t_alu_out;

    typedef struct packed {
        logic [4:0]  cmd;
        logic [15:0] a;
        logic [7:0]  b;
        logic [15:0] op_b;
        logic        cy;
        logic [2:0]  bit_index;
        logic [3:0]  fin;
        logic        daa_c;
    } t_dec;

    typedef struct packed {
        logic [15:0] r;
        logic        z_calc;
        logic        z_val;
        logic        n;
        logic        h;
        logic        c;
    } t_exe;

endpackage

/* rtl/ebalu_dec.sv */
// Stage one: operand selection, carry-in and decimal-adjust correction.
module ebalu_dec (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ebalu_pkg::t_alu_in i_item,
    output logic              o_valid,
    output ebalu_pkg::t_dec   o_dec
);

    logic            r_valid;
    ebalu_pkg::t_dec r_dec;
    ebalu_pkg::t_dec n_dec;
    logic [7:0]      a8;
    logic [7:0]      b8;
    logic            sub;
    logic            lo_adj;
    logic            hi_adj;
    logic [7:0]      corr;

    always_comb begin
        a8     = i_item.first_operand[7:0];
        b8     = i_item.second_operand[7:0];
        sub    = i_item.flags_in[ebalu_pkg::FLAG_N];
        lo_adj = i_item.flags_in[ebalu_pkg::FLAG_H] || (!sub && a8[3:0] > ebalu_pkg::DAA_LO_LIM);
        hi_adj = i_item.flags_in[ebalu_pkg::FLAG_C] || (!sub && a8 > ebalu_pkg::DAA_HI_LIM);
        corr   = (lo_adj ? ebalu_pkg::DAA_LO_ADJ : 8'h00) | (hi_adj ? ebalu_pkg::DAA_HI_ADJ : 8'h00);

        n_dec.cmd       = i_item.command;
        n_dec.a         = i_item.first_operand;
        n_dec.b         = b8;
        n_dec.bit_index = i_item.bit_index;
        n_dec.fin       = i_item.flags_in;
        n_dec.daa_c     = hi_adj;
        n_dec.op_b      = {8'h00, b8};
        n_dec.cy        = 1'b0;

        case (i_item.command)
            ebalu_pkg::CMD_ADC: begin
                n_dec.cy = i_item.flags_in[ebalu_pkg::FLAG_C];
            end
            ebalu_pkg::CMD_SUB: begin
                n_dec.op_b = {8'hFF, ~b8};
                n_dec.cy   = 1'b1;
            end
            ebalu_pkg::CMD_SBC: begin
                n_dec.op_b = {8'hFF, ~b8};
                n_dec.cy   = !i_item.flags_in[ebalu_pkg::FLAG_C];
            end
            ebalu_pkg::CMD_INC: begin
                n_dec.op_b = 16'h0001;
            end
            ebalu_pkg::CMD_DEC: begin
                n_dec.op_b = 16'hFFFE;
                n_dec.cy   = 1'b1;
            end
            ebalu_pkg::CMD_DAA: begin
                if (sub) begin
                    n_dec.op_b = {8'hFF, ~corr};
                    n_dec.cy   = 1'b1;
                end else begin
                    n_dec.op_b = {8'h00, corr};
                end
            end
            ebalu_pkg::CMD_ADD16: begin
                n_dec.op_b = i_item.second_operand;
            end
            ebalu_pkg::CMD_ADD16S: begin
                n_dec.op_b = {{8{b8[7]}}, b8};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec <= n_dec;
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

/* rtl/ebalu_exe.sv */
// Stage two: segmented adder, logic, shift and bit operations with partial flags.
module ebalu_exe (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ebalu_pkg::t_dec i_dec,
    output logic            o_valid,
    output ebalu_pkg::t_exe o_exe
);

    logic            r_valid;
    ebalu_pkg::t_exe r_exe;
    ebalu_pkg::t_exe n_exe;
    logic [4:0]      s5;
    logic [8:0]      s9;
    logic [12:0]     s13;
    logic [16:0]     s17;
    logic [7:0]      a8;
    logic            cin;

    always_comb begin
        a8  = i_dec.a[7:0];
        cin = i_dec.fin[ebalu_pkg::FLAG_C];
        s5  = {1'b0, i_dec.a[3:0]} + {1'b0, i_dec.op_b[3:0]} + {4'd0, i_dec.cy};
        s9  = {1'b0, i_dec.a[7:0]} + {1'b0, i_dec.op_b[7:0]} + {8'd0, i_dec.cy};
        s13 = {1'b0, i_dec.a[11:0]} + {1'b0, i_dec.op_b[11:0]} + {12'd0, i_dec.cy};
        s17 = {1'b0, i_dec.a} + {1'b0, i_dec.op_b} + {16'd0, i_dec.cy};

        n_exe.r      = {8'h00, s17[7:0]};
        n_exe.z_calc = 1'b1;
        n_exe.z_val  = 1'b0;
        n_exe.n      = 1'b0;
        n_exe.h      = 1'b0;
        n_exe.c      = 1'b0;

        case (i_dec.cmd)
            ebalu_pkg::CMD_ADD, ebalu_pkg::CMD_ADC: begin
                n_exe.h = s5[4];
                n_exe.c = s9[8];
            end
            ebalu_pkg::CMD_SUB, ebalu_pkg::CMD_SBC: begin
                n_exe.n = 1'b1;
                n_exe.h = !s5[4];
                n_exe.c = !s9[8];
            end
            ebalu_pkg::CMD_AND: begin
                n_exe.r = {8'h00, a8 & i_dec.b};
                n_exe.h = 1'b1;
            end
            ebalu_pkg::CMD_OR: begin
                n_exe.r = {8'h00, a8 | i_dec.b};
            end
            ebalu_pkg::CMD_XOR: begin
                n_exe.r = {8'h00, a8 ^ i_dec.b};
            end
            ebalu_pkg::CMD_INC: begin
                n_exe.h = s5[4];
                n_exe.c = cin;
            end
            ebalu_pkg::CMD_DEC: begin
                n_exe.n = 1'b1;
                n_exe.h = !s5[4];
                n_exe.c = cin;
            end
            ebalu_pkg::CMD_DAA: begin
                n_exe.n = i_dec.fin[ebalu_pkg::FLAG_N];
                n_exe.c = i_dec.daa_c;
            end
            ebalu_pkg::CMD_RLC, ebalu_pkg::CMD_RLCA: begin
                n_exe.r = {8'h00, a8[6:0], a8[7]};
                n_exe.c = a8[7];
            end
            ebalu_pkg::CMD_RRC, ebalu_pkg::CMD_RRCA: begin
                n_exe.r = {8'h00, a8[0], a8[7:1]};
                n_exe.c = a8[0];
            end
            ebalu_pkg::CMD_RL, ebalu_pkg::CMD_RLA: begin
                n_exe.r = {8'h00, a8[6:0], cin};
                n_exe.c = a8[7];
            end
            ebalu_pkg::CMD_RR, ebalu_pkg::CMD_RRA: begin
                n_exe.r = {8'h00, cin, a8[7:1]};
                n_exe.c = a8[0];
            end
            ebalu_pkg::CMD_SLA: begin
                n_exe.r = {8'h00, a8[6:0], 1'b0};
                n_exe.c = a8[7];
            end
            ebalu_pkg::CMD_SRA: begin
                n_exe.r = {8'h00, a8[7], a8[7:1]};
                n_exe.c = a8[0];
            end
            ebalu_pkg::CMD_SWAP: begin
                n_exe.r = {8'h00, a8[3:0], a8[7:4]};
            end
            ebalu_pkg::CMD_SRL: begin
                n_exe.r = {8'h00, 1'b0, a8[7:1]};
                n_exe.c = a8[0];
            end
            ebalu_pkg::CMD_BIT: begin
                n_exe.r      = {8'h00, a8};
                n_exe.z_calc = 1'b0;
                n_exe.z_val  = !a8[i_dec.bit_index];
                n_exe.h      = 1'b1;
                n_exe.c      = cin;
            end
            ebalu_pkg::CMD_RES, ebalu_pkg::CMD_SET: begin
                if (i_dec.cmd == ebalu_pkg::CMD_SET) begin
                    n_exe.r = {8'h00, a8 | (8'd1 << i_dec.bit_index)};
                end else begin
                    n_exe.r = {8'h00, a8 & ~(8'd1 << i_dec.bit_index)};
                end
                n_exe.z_calc = 1'b0;
                n_exe.z_val  = i_dec.fin[ebalu_pkg::FLAG_Z];
                n_exe.n      = i_dec.fin[ebalu_pkg::FLAG_N];
                n_exe.h      = i_dec.fin[ebalu_pkg::FLAG_H];
                n_exe.c      = cin;
            end
            ebalu_pkg::CMD_ADD16: begin
                n_exe.r      = s17[15:0];
                n_exe.z_calc = 1'b0;
                n_exe.z_val  = i_dec.fin[ebalu_pkg::FLAG_Z];
                n_exe.h      = s13[12];
                n_exe.c      = s17[16];
            end
            ebalu_pkg::CMD_ADD16S: begin
                n_exe.r      = s17[15:0];
                n_exe.z_calc = 1'b0;
                n_exe.h      = s5[4];
                n_exe.c      = s9[8];
            end
            default: begin
                n_exe.r      = i_dec.a;
                n_exe.z_calc = 1'b0;
                n_exe.z_val  = i_dec.fin[ebalu_pkg::FLAG_Z];
                n_exe.n      = i_dec.fin[ebalu_pkg::FLAG_N];
                n_exe.h      = i_dec.fin[ebalu_pkg::FLAG_H];
                n_exe.c      = cin;
            end
        endcase

        if (i_dec.cmd inside {[ebalu_pkg::CMD_RLCA : ebalu_pkg::CMD_RRA]}) begin
            n_exe.z_calc = 1'b0;
            n_exe.z_val  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exe <= n_exe;
    end

    assign o_valid = r_valid;
    assign o_exe   = r_exe;

endmodule

/* rtl/ebalu_flg.sv */
// Stage three: zero detection, final flag assembly and the output register.
module ebalu_flg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  ebalu_pkg::t_exe    i_exe,
    output logic               o_valid,
    output ebalu_pkg::t_alu_out o_result
);

    logic                r_valid;
    ebalu_pkg::t_alu_out r_out;
    ebalu_pkg::t_alu_out n_out;
    logic                z;

    always_comb begin
        z               = i_exe.z_calc ? (i_exe.r[7:0] == 8'h00) : i_exe.z_val;
        n_out.result    = i_exe.r;
        n_out.flags_out = {z, i_exe.n, i_exe.h, i_exe.c};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

/* rtl/eight_bit_cpu_alu_with_flags.sv */
// Top level of the 8-bit CPU ALU with flags, a three-stage pipeline.
// A transaction taken with start passes the dec, exe and flg stage registers to o_result.
// Throughput: one transaction per cycle; busy stays low, so start is always taken.
// The result strobe o_valid lasts one cycle and the receiver cannot stall it.
// Synchronous active-low reset clears the stage valid bits only.
module eight_bit_cpu_alu_with_flags (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ebalu_pkg::t_alu_in  i_item,
    output logic                o_valid,
    output ebalu_pkg::t_alu_out o_result
);

    logic            dec_valid;
    ebalu_pkg::t_dec dec;
    logic            exe_valid;
    ebalu_pkg::t_exe exe;

    assign busy = 1'b0;

    ebalu_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_item  (i_item),
        .o_valid (dec_valid),
        .o_dec   (dec)
    );

    ebalu_exe u_exe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .i_dec   (dec),
        .o_valid (exe_valid),
        .o_exe   (exe)
    );

    ebalu_flg u_flg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (exe_valid),
        .i_exe    (exe),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    a_valid_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 3))
        else $error("Result strobe without a matching start.");

    a_valid_delivered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start ##1 i_rst_n ##1 i_rst_n |=> o_valid)
        else $error("Accepted transaction was not delivered.");

    a_set_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_item.command, 3) == ebalu_pkg::CMD_SET
        |-> o_result.result[$past(i_item.bit_index, 3)] && o_result.result[15:8] == 8'h00)
        else $error("Bit set result is wrong.");

    a_acc_rot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ($past(i_item.command, 3) == ebalu_pkg::CMD_RLCA
            || $past(i_item.command, 3) == ebalu_pkg::CMD_RRCA
            || $past(i_item.command, 3) == ebalu_pkg::CMD_RLA
            || $past(i_item.command, 3) == ebalu_pkg::CMD_RRA)
        |-> !o_result.flags_out[ebalu_pkg::FLAG_Z])
        else $error("Accumulator rotate left the zero flag set.");

endmodule
